// File: src/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and codes of the compacting region table.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int ID_W   = 8;
  localparam int ADDR_W = 64;
  localparam int SIZE_W = 64;
  localparam int RSZ_W  = 63;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 7;

  localparam logic [SIZE_W-1:0] SIZE_ROUND = 64'd3;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_READ_OK   = 3'd2,
    ST_INVALID   = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_FULL      = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_BAD_SLOT  = 3'd7
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              add_go;
    logic              rem_go;
    logic [ID_W-1:0]   key;
    logic [SLOT_W-1:0] rd_slot;
  } cell_ctl_t;

endpackage

// File: src/crt_if.sv
// ----------------------------------------------------------------------------
// crt_in_if / crt_out_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface crt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  region_id;
  logic [63:0] phys_addr;
  logic [63:0] virt_addr;
  logic [62:0] region_size;
  logic [5:0]  read_slot;

  modport source (output valid, command, region_id, phys_addr, virt_addr, region_size,
                  read_slot, input ready);
  modport sink (input valid, command, region_id, phys_addr, virt_addr, region_size,
                read_slot, output ready);
endinterface

interface crt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [6:0]  entry_count;
  logic [7:0]  entry_id;
  logic [63:0] entry_address;
  logic [63:0] entry_size;

  modport source (output valid, status, slot, entry_count, entry_id, entry_address,
                  entry_size, input ready);
  modport sink (input valid, status, slot, entry_count, entry_id, entry_address,
                entry_size, output ready);
endinterface

// File: src/compacting_region_table.sv
// ----------------------------------------------------------------------------
// compacting_region_table
// Dense region table built as a row of slot cells with shift-down removal.
// ----------------------------------------------------------------------------
// Requests enter on in_ch (add, remove, read slot); one response word per
// request leaves on out_ch. linear_map_offset sits at APB address 0.
// A request is registered in the accept cycle; in the execute step the id
// is broadcast to every cell, which compare in parallel; the match
// ripples up the row so that the hit cell and every cell above it load
// their upper neighbour in that same step, and the response is registered.
// The next request is taken only after the current one has executed.
// in_ch.ready is high whenever no request is executing, so a new word is
// taken while a response waits. If out_ch stalls, the execute step holds
// (table unchanged) until the response register frees up. Reset (rst_n
// low, synchronous) empties the table via per-slot valid bits, clears the
// count and the offset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module compacting_region_table #(
  parameter int MAX_REGIONS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  crt_in_if.sink      in_ch,
  crt_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import crt_pkg::*;

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t             state_r;
  logic [1:0]         cmd_r;
  logic [ID_W-1:0]    id_r;
  logic [ADDR_W-1:0]  pa_r;
  logic [ADDR_W-1:0]  va_r;
  logic [RSZ_W-1:0]   size_r;
  logic [SLOT_W-1:0]  rslot_r;
  logic [ADDR_W-1:0]  off_r;
  logic [CW-1:0]      count_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [CNT_W-1:0]   out_count_r;
  entry_t             out_entry_r;

  logic [MAX_REGIONS-1:0] v;
  logic [MAX_REGIONS-1:0] hit;
  logic [MAX_REGIONS:0]   chain;
  entry_t                 ent  [MAX_REGIONS];
  entry_t                 rd   [MAX_REGIONS];

  cell_ctl_t          ctl;
  entry_t             new_entry;
  entry_t             rd_entry;
  logic [IW-1:0]      hit_idx;
  logic               any_hit;
  logic               go;
  logic               rd_bad;
  status_t            res_status;
  logic [SLOT_W-1:0]  res_slot;
  entry_t             res_entry;
  logic [CW-1:0]      count_nxt;
  logic               add_ok;
  logic               rem_ok;
  logic               cfg_wr;

  // ---- configuration ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[3];
  assign cfg_prdata = cfg_paddr[3] ? '0 : off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (cfg_wr) begin
      off_r <= cfg_pwdata;
    end
  end

  // ---- cell row ----
  assign go               = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign ctl.add_go       = go && add_ok;
  assign ctl.rem_go       = go && rem_ok;
  assign ctl.key          = id_r;
  assign ctl.rd_slot      = rslot_r;
  assign new_entry.id     = id_r;
  assign new_entry.addr   = (pa_r != '0) ? pa_r : (va_r - off_r);
  assign new_entry.size   = ({1'b0, size_r} + SIZE_ROUND) & ~SIZE_ROUND;
  assign chain[0]         = 1'b0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    logic   nv;
    entry_t ne;
    if (i == MAX_REGIONS - 1) begin : g_top
      assign nv = 1'b0;
      assign ne = '0;
    end else begin : g_mid
      assign nv = v[i+1];
      assign ne = ent[i+1];
    end
    crt_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .count     (count_r),
      .new_entry (new_entry),
      .nbr_v     (nv),
      .nbr_entry (ne),
      .chain_i   (chain[i]),
      .chain_o   (chain[i+1]),
      .hit_o     (hit[i]),
      .v_o       (v[i]),
      .entry_o   (ent[i]),
      .rd_o      (rd[i])
    );
  end

  assign any_hit = chain[MAX_REGIONS];

  always_comb begin
    hit_idx  = '0;
    rd_entry = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      hit_idx  = hit_idx | (hit[i] ? IW'(i) : '0);
      rd_entry = rd_entry | rd[i];
    end
  end

  // ---- execute ----
  assign rd_bad = int'(rslot_r) >= MAX_REGIONS;

  always_comb begin
    res_status = ST_INVALID;
    res_slot   = '0;
    res_entry  = '0;
    count_nxt  = count_r;
    add_ok     = 1'b0;
    rem_ok     = 1'b0;
    unique case (cmd_r)
      CMD_ADD: begin
        if ((pa_r == '0 && va_r == '0) || size_r == '0) begin
          res_status = ST_INVALID;
        end else if (any_hit) begin
          res_status = ST_DUPLICATE;
        end else if (count_r == CW'(MAX_REGIONS)) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_ADDED;
          res_slot   = SLOT_W'(count_r);
          count_nxt  = count_r + 1'b1;
          add_ok     = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (any_hit) begin
          res_status = ST_REMOVED;
          res_slot   = SLOT_W'(hit_idx);
          count_nxt  = count_r - 1'b1;
          rem_ok     = 1'b1;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (rd_bad) begin
          res_status = ST_BAD_SLOT;
        end else begin
          res_status = ST_READ_OK;
          res_slot   = rslot_r;
          res_entry  = rd_entry;
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (go) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r   <= in_ch.command;
      id_r    <= in_ch.region_id;
      pa_r    <= in_ch.phys_addr;
      va_r    <= in_ch.virt_addr;
      size_r  <= in_ch.region_size;
      rslot_r <= in_ch.read_slot;
    end
    if (go) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_count_r  <= CNT_W'(count_nxt);
      out_entry_r  <= res_entry;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.entry_count   = out_count_r;
  assign out_ch.entry_id      = out_entry_r.id;
  assign out_ch.entry_address = out_entry_r.addr;
  assign out_ch.entry_size    = out_entry_r.size;

  // ---- checks ----
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REGIONS))
    else $error("entry count beyond table depth");

  a_valid_dense: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(v) == int'(count_r))
    else $error("valid slots disagree with entry count");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("id held in more than one slot");

  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("response raised without an execute step");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.add_go |=> count_r == $past(count_r) + 1'b1)
    else $error("add did not grow the table");

endmodule

// File: src/crt_cell.sv
// ----------------------------------------------------------------------------
// crt_cell
// One table slot: holds an entry, matches the key and shifts down on removal.
// ----------------------------------------------------------------------------
module crt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crt_pkg::cell_ctl_t   ctl,
  input  logic [CW-1:0]        count,
  input  crt_pkg::entry_t      new_entry,
  input  logic                 nbr_v,
  input  crt_pkg::entry_t      nbr_entry,
  input  logic                 chain_i,
  output logic                 chain_o,
  output logic                 hit_o,
  output logic                 v_o,
  output crt_pkg::entry_t      entry_o,
  output crt_pkg::entry_t      rd_o
);
  import crt_pkg::*;

  logic   v_r;
  entry_t ent_r;
  logic   at_end;
  logic   shift;
  logic   rd_sel;

  assign at_end  = (count == CW'(IDX));
  assign hit_o   = v_r && (ent_r.id == ctl.key);
  assign chain_o = hit_o | chain_i;
  assign shift   = ctl.rem_go && chain_o;
  assign rd_sel  = v_r && (int'(ctl.rd_slot) == IDX);
  assign v_o     = v_r;
  assign entry_o = ent_r;
  assign rd_o    = rd_sel ? ent_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (shift) begin
      v_r <= nbr_v;
    end else if (ctl.add_go && at_end) begin
      v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ent_r <= nbr_entry;
    end else if (ctl.add_go && at_end) begin
      ent_r <= new_entry;
    end
  end

endmodule
